/* hdl/median_outlier_reject_average_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the median outlier reject average block
// Clocked implications, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_OUTLIER_REJECT_AVERAGE_MACROS_SVH
`define MEDIAN_OUTLIER_REJECT_AVERAGE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define MORA_CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MORA_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mora_pkg.sv */
// ----------------------------------------------------------------------------
// mora_pkg
// Shared constants, codes and item types of the median outlier reject average.
// ----------------------------------------------------------------------------
package mora_pkg;

  // Store capacity and derived widths
  localparam int MAX_SAMPLES = 16;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  // Field widths
  localparam int OFF_W       = 32;
  localparam int GOOD_CNT_W  = 5;
  localparam int SUM_W       = 36;
  localparam int CORR_W      = 52;
  localparam int LIMIT_W     = 31;
  localparam int PREC_W      = 19;

  // Configuration port
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 31;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(31536000);

  // Scaling to microseconds and divider sizing
  localparam int US_PER_SEC  = 1000000;
  localparam int US_W        = 21;
  localparam int PROD_W      = SUM_W + US_W;
  localparam int STEP_W      = $clog2(PROD_W + 1);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ALL_FAILED = 2'd1,
    ST_NO_SAMPLE  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_LIMIT = 1'b0,
    CFG_PRECISION  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] offset_sec;
    logic                    failed;
    logic                    last_sample;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [OFF_W-1:0]  median_sec;
    logic [GOOD_CNT_W-1:0]    good_count;
    logic signed [SUM_W-1:0]  good_sum;
    logic signed [CORR_W-1:0] correction_us;
    logic                     overflowed;
  } out_item_t;

endpackage

/* hdl/median_outlier_reject_average.sv */
// ----------------------------------------------------------------------------
// median_outlier_reject_average
// Collects a round of clock-offset samples and returns the mean of those
// within one second of their upper median, as a correction in microseconds.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An item without
// last_sample is absorbed while busy stays low. An item with last_sample
// whose round has no success or no kept sample gives its result on the next
// cycle. Otherwise busy rises and the result follows after k candidates
// (1..n) are tried before the upper median is found, n being the number of
// kept samples: each candidate is ranked by one subtract unit that scans the
// single read port of the sample store, the sum pass scans it once more, and
// the correction comes out of a one-bit-per-cycle divider of 57 steps.
// out_strobe is high for exactly one cycle per result and cannot be held
// off: the receiver must take it then.
// Configuration writes are taken at any cycle; they are meant for idle time.
module median_outlier_reject_average (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  mora_pkg::in_item_t                   in_item,
  output logic                                 out_strobe,
  output mora_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic [mora_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mora_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CRD  = 9'b000000010,
    S_CAP  = 9'b000000100,
    S_SCAN = 9'b000001000,
    S_EVAL = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_ABS  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  localparam int AW  = mora_pkg::ADDR_W;
  localparam int CW  = mora_pkg::CNT_W;
  localparam int OW  = mora_pkg::OFF_W;
  localparam int SW  = mora_pkg::SUM_W;
  localparam int PW  = mora_pkg::PROD_W;

  // Control state
  state_t                          state_r, state_nxt;
  logic [mora_pkg::LIMIT_W-1:0]    time_limit_r, time_limit_nxt;
  logic [mora_pkg::PREC_W-1:0]     precision_r, precision_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic                            success_r, success_nxt;
  logic                            ovf_r, ovf_nxt;
  logic                            out_strobe_r, out_strobe_nxt;

  // Working registers
  logic [CW-1:0]                   cand_idx_r, cand_idx_nxt;
  logic [CW-1:0]                   j_r, j_nxt;
  logic                            phase_r, phase_nxt;
  logic signed [OW-1:0]            cand_r, cand_nxt;
  logic [CW-1:0]                   acc_a_r, acc_a_nxt;
  logic [CW-1:0]                   acc_b_r, acc_b_nxt;
  logic signed [SW-1:0]            sum_r, sum_nxt;
  logic signed [PW-1:0]            prod_r, prod_nxt;
  logic [PW-1:0]                   dvd_r, dvd_nxt;
  logic [CW-1:0]                   rem_r, rem_nxt;
  logic [mora_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic                            neg_r, neg_nxt;
  mora_pkg::out_item_t             out_r, out_nxt;

  // Store ports
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [OW-1:0]                   ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [OW-1:0]                   ram_rdata;

  // Input qualification
  logic                            accept;
  logic signed [OW:0]              off_x;
  logic signed [OW:0]              lim_x;
  logic                            in_range;
  logic                            keep;
  logic                            full;
  logic                            succ_n;
  logic                            ovf_n;
  logic [CW-1:0]                   cnt_n;

  // Shared compare unit and divider step
  logic signed [OW:0]              diff;
  logic                            is_lt;
  logic                            is_le;
  logic                            is_near;
  logic [CW-1:0]                   half;
  logic                            found;
  logic [CW:0]                     rem_sh;
  logic                            div_ge;
  logic [CW:0]                     rem_sub;
  logic signed [mora_pkg::US_W-1:0] us_c;

  // Final correction
  logic signed [PW:0]              quot_s;
  logic signed [SW:0]              sum_x;
  logic signed [SW:0]              cnt_x;
  logic                            near_zero;
  logic signed [mora_pkg::CORR_W-1:0] corr;
  logic signed [mora_pkg::CORR_W-1:0] prec_s;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  // Sample qualification: keep only good samples strictly inside the limit
  assign off_x    = (OW+1)'(in_item.offset_sec);
  assign lim_x    = $signed({{(OW+1-mora_pkg::LIMIT_W){1'b0}}, time_limit_r});
  assign in_range = (off_x < lim_x) && (off_x > -lim_x);
  assign keep     = !in_item.failed && in_range;
  assign full     = (count_r == CW'(mora_pkg::MAX_SAMPLES));
  assign succ_n   = success_r || !in_item.failed;
  assign ovf_n    = ovf_r || (keep && full);
  assign cnt_n    = count_r + CW'(ram_we);

  assign ram_we    = accept && keep && !full;
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = in_item.offset_sec;

  // Shared subtract unit: stored sample minus candidate
  assign diff    = (OW+1)'($signed(ram_rdata)) - (OW+1)'(cand_r);
  assign is_lt   = diff < 0;
  assign is_le   = diff <= 0;
  assign is_near = (diff >= -1) && (diff <= 1);
  assign half    = count_r >> 1;
  assign found   = (acc_a_r <= half) && (acc_b_r > half);

  // Restoring divider step, one quotient bit a cycle
  assign rem_sh  = {rem_r, dvd_r[PW-1]};
  assign div_ge  = rem_sh >= {1'b0, acc_a_r};
  assign rem_sub = rem_sh - {1'b0, acc_a_r};
  assign us_c    = mora_pkg::US_W'(mora_pkg::US_PER_SEC);

  // Signed quotient and precision step
  assign quot_s    = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
  assign sum_x     = (SW+1)'(sum_r);
  assign cnt_x     = $signed({{(SW+1-CW){1'b0}}, acc_a_r});
  assign near_zero = (sum_x < cnt_x) && (sum_x > -cnt_x);
  assign prec_s    = $signed({{(mora_pkg::CORR_W-mora_pkg::PREC_W){1'b0}}, precision_r});

  always_comb begin
    corr = mora_pkg::CORR_W'(quot_s);
    if ((precision_r != '0) && near_zero) begin
      corr = (sum_r < 0) ? -prec_s : prec_s;
    end
  end

  // Store read address per sequencer step
  always_comb begin
    case (state_r)
      S_CRD:   ram_raddr = cand_idx_r[AW-1:0];
      S_SCAN:  ram_raddr = j_r[AW-1:0];
      default: ram_raddr = '0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    time_limit_nxt = time_limit_r;
    precision_nxt  = precision_r;
    count_nxt      = count_r;
    success_nxt    = success_r;
    ovf_nxt        = ovf_r;
    out_strobe_nxt = 1'b0;
    cand_idx_nxt   = cand_idx_r;
    j_nxt          = j_r;
    phase_nxt      = phase_r;
    cand_nxt       = cand_r;
    acc_a_nxt      = acc_a_r;
    acc_b_nxt      = acc_b_r;
    sum_nxt        = sum_r;
    prod_nxt       = prod_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    neg_nxt        = neg_r;
    out_nxt        = out_r;

    // Register writes
    if (cfg_we) begin
      case (cfg_index)
        mora_pkg::CFG_TIME_LIMIT: time_limit_nxt = cfg_data[mora_pkg::LIMIT_W-1:0];
        mora_pkg::CFG_PRECISION:  precision_nxt  = cfg_data[mora_pkg::PREC_W-1:0];
        default:                  time_limit_nxt = time_limit_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          count_nxt   = cnt_n;
          success_nxt = succ_n;
          ovf_nxt     = ovf_n;
          if (in_item.last_sample) begin
            if (!succ_n || (cnt_n == '0)) begin
              // Round ends without a usable sample: report and drop the round
              out_nxt               = '0;
              out_nxt.status        = !succ_n ? mora_pkg::ST_ALL_FAILED
                                              : mora_pkg::ST_NO_SAMPLE;
              out_nxt.overflowed    = ovf_n;
              out_strobe_nxt        = 1'b1;
              count_nxt             = '0;
              success_nxt           = 1'b0;
              ovf_nxt               = 1'b0;
            end else begin
              cand_idx_nxt = '0;
              state_nxt    = S_CRD;
            end
          end
        end
      end

      S_CRD: begin
        state_nxt = S_CAP;
      end

      // Latch candidate, start the rank scan at entry zero
      S_CAP: begin
        cand_nxt  = $signed(ram_rdata);
        acc_a_nxt = '0;
        acc_b_nxt = '0;
        j_nxt     = CW'(1);
        phase_nxt = 1'b0;
        state_nxt = S_SCAN;
      end

      // Compare entry j-1 against the candidate; read entry j
      S_SCAN: begin
        if (!phase_r) begin
          acc_a_nxt = acc_a_r + CW'(is_lt);
          acc_b_nxt = acc_b_r + CW'(is_le);
        end else if (is_near) begin
          acc_a_nxt = acc_a_r + CW'(1);
          sum_nxt   = sum_r + SW'($signed(ram_rdata));
        end
        if (j_r == count_r) begin
          state_nxt = phase_r ? S_MUL : S_EVAL;
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end

      // Upper median found: sum its neighbors; else try the next candidate
      S_EVAL: begin
        if (found) begin
          phase_nxt = 1'b1;
          acc_a_nxt = '0;
          sum_nxt   = '0;
          j_nxt     = CW'(1);
          state_nxt = S_SCAN;
        end else begin
          cand_idx_nxt = cand_idx_r + CW'(1);
          state_nxt    = S_CRD;
        end
      end

      S_MUL: begin
        prod_nxt  = sum_r * us_c;
        state_nxt = S_ABS;
      end

      S_ABS: begin
        neg_nxt   = prod_r < 0;
        dvd_nxt   = (prod_r < 0) ? PW'(-prod_r) : PW'(prod_r);
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end

      S_DIV: begin
        dvd_nxt  = {dvd_r[PW-2:0], div_ge};
        rem_nxt  = div_ge ? CW'(rem_sub) : CW'(rem_sh);
        step_nxt = step_r + mora_pkg::STEP_W'(1);
        if (step_r == mora_pkg::STEP_W'(PW - 1)) begin
          state_nxt = S_DONE;
        end
      end

      // Emit the result and clear the round
      S_DONE: begin
        out_nxt.status        = mora_pkg::ST_OK;
        out_nxt.median_sec    = cand_r;
        out_nxt.good_count    = mora_pkg::GOOD_CNT_W'(acc_a_r);
        out_nxt.good_sum      = sum_r;
        out_nxt.correction_us = corr;
        out_nxt.overflowed    = ovf_r;
        out_strobe_nxt        = 1'b1;
        count_nxt             = '0;
        success_nxt           = 1'b0;
        ovf_nxt               = 1'b0;
        state_nxt             = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      time_limit_r <= mora_pkg::LIMIT_RESET;
      precision_r  <= '0;
      count_r      <= '0;
      success_r    <= 1'b0;
      ovf_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      time_limit_r <= time_limit_nxt;
      precision_r  <= precision_nxt;
      count_r      <= count_nxt;
      success_r    <= success_nxt;
      ovf_r        <= ovf_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cand_idx_r <= cand_idx_nxt;
    j_r        <= j_nxt;
    phase_r    <= phase_nxt;
    cand_r     <= cand_nxt;
    acc_a_r    <= acc_a_nxt;
    acc_b_r    <= acc_b_nxt;
    sum_r      <= sum_nxt;
    prod_r     <= prod_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    neg_r      <= neg_nxt;
    out_r      <= out_nxt;
  end

  // Sample store
  mora_ram #(
    .WIDTH (OW),
    .DEPTH (mora_pkg::MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* hdl/mora_ram.sv */
// ----------------------------------------------------------------------------
// mora_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mora_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/mora_checker.sv */
// ----------------------------------------------------------------------------
// mora_checker
// Port-level checks of the median outlier reject average, bound to the top.
// ----------------------------------------------------------------------------
`include "median_outlier_reject_average_macros.svh"

module mora_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input mora_pkg::in_item_t  in_item,
  input logic                out_strobe,
  input mora_pkg::out_item_t out_item
);

  // A closing item either reports at once or starts the computation
  `MORA_CHK_NEXT(a_last_acts, start && !busy && in_item.last_sample, out_strobe || busy, "closing item neither reported nor computed")

  // Any other item is absorbed without a result or a stall
  `MORA_CHK_NEXT(a_plain_quiet, start && !busy && !in_item.last_sample, !busy && !out_strobe, "plain item caused a result or stall")

  // The end of a computation is marked by a result
  `MORA_CHK_SAME(a_fall_reports, $fell(busy), out_strobe, "computation ended without a result")

  // An error result carries no numbers
  `MORA_CHK_SAME(a_err_zero, out_strobe && out_item.status != mora_pkg::ST_OK, out_item.good_count == 0 && out_item.correction_us == 0 && out_item.median_sec == 0, "error result carries data")

endmodule

bind median_outlier_reject_average mora_checker u_mora_checker (.*);
